// ----- design/chebyshev_clenshaw_eval_3d_defines.svh -----
// Assertion macros used by the evaluator's top-level RTL file.
`ifndef CHEBYSHEV_CLENSHAW_EVAL_3D_DEFINES_SVH
`define CHEBYSHEV_CLENSHAW_EVAL_3D_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define CCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define CCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cce_pkg.sv -----
package cce_pkg;

  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = 6;
  localparam int NUM_AXES  = 3;
  localparam int DIV_W     = 100;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_POS   = 2'd1;
  localparam logic [1:0] FUNC_DERIV = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAT      = 2'd1;
  localparam logic [1:0] ST_ZERO_RAD = 2'd2;

  localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] HALF_DAY_SCALE = 32'd43200;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         term_index;
    logic signed [63:0] coef_x;
    logic signed [63:0] coef_y;
    logic signed [63:0] coef_z;
    logic signed [31:0] t_norm;
    logic [31:0]        radius_days;
  } cce_in_t;

  typedef struct packed {
    logic signed [63:0] out_x;
    logic signed [63:0] out_y;
    logic signed [63:0] out_z;
    logic [1:0]         status;
  } cce_out_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } cce_coef_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  // Saturate a magnitude to the signed 64-bit range and apply the sign.
  // Bit 64 of the result is the saturation flag.
  function automatic logic [64:0] pack_mag(input logic [127:0] m, input logic neg);
    logic [63:0] limit;
    logic [63:0] v;
    logic        s;
    limit = neg ? SIGN64 : MAXPOS64;
    s     = (m[127:64] != '0) || (m[63:0] > limit);
    v     = s ? limit : m[63:0];
    return {s, (neg ? (~v + 64'd1) : v)};
  endfunction

  // Saturating add; bit 64 is the saturation flag.
  function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic        s;
    r = a + b;
    s = (a[63] == b[63]) && (r[63] != a[63]);
    return {s, (s ? (a[63] ? SIGN64 : MAXPOS64) : r)};
  endfunction

  // Saturating subtract; bit 64 is the saturation flag.
  function automatic logic [64:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic        s;
    r = a - b;
    s = (a[63] != b[63]) && (r[63] != a[63]);
    return {s, (s ? (a[63] ? SIGN64 : MAXPOS64) : r)};
  endfunction

endpackage

// ----- design/cce_coef_mem.sv -----
module cce_coef_mem (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [cce_pkg::IDX_W-1:0] wr_addr_i,
  input  cce_pkg::cce_coef_t       wr_data_i,
  input  logic                     rd_en_i,
  input  logic [cce_pkg::IDX_W-1:0] rd_addr_i,
  output cce_pkg::cce_coef_t       rd_data_o
);
  import cce_pkg::*;

  cce_coef_t mem_q [MAX_TERMS];
  cce_coef_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- design/cce_divider.sv -----
module cce_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cce_pkg::DIV_W-1:0] dividend_i,
  input  logic [31:0]              divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [cce_pkg::DIV_W-1:0] quot_o,
  output logic [31:0]              rem_o
);
  import cce_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quot_q;
  logic [31:0]          rem_q;
  logic [31:0]          div_q;
  logic [32:0]          rem_shift;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_shift = {rem_q, quot_q[DIV_W-1]};
  assign ge        = rem_shift >= {1'b0, div_q};

  // Control: a count of remaining steps and a done pulse after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], ge};
      rem_q  <= ge ? 32'(rem_shift - {1'b0, div_q}) : rem_shift[31:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/chebyshev_clenshaw_eval_3d.sv -----
// A load word is written to the coefficient store while the sequencer stays idle. For
// each term of an evaluation and each axis the sequencer passes through read, low and high
// multiply, round and accumulate states on the shared 32x32 multiplier, and the derivative
// scale is a 100-step bit-serial divide per axis. One word is worked at a time.
// A derivative with fewer than two terms or a zero radius goes straight to the done state.
// Reset is asynchronous, active low; term_count resets to 1 and the coefficient store is
// undefined until written.
`include "chebyshev_clenshaw_eval_3d_defines.svh"

module chebyshev_clenshaw_eval_3d (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  cce_pkg::cce_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cce_pkg::cce_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cce_pkg::CNT_W-1:0] cfg_data_i
);
  import cce_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RD   = 11'b000_0000_0010,
    S_MUL0 = 11'b000_0000_0100,
    S_MUL1 = 11'b000_0000_1000,
    S_RND  = 11'b000_0001_0000,
    S_ACC  = 11'b000_0010_0000,
    S_SC0  = 11'b000_0100_0000,
    S_SC1  = 11'b000_1000_0000,
    S_DVS  = 11'b001_0000_0000,
    S_DIV  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] term_count_q;
  logic             out_valid_q;
  cce_out_t         out_data_q;

  logic             deriv_q;
  logic             rad0_q;
  logic             sat_q;
  logic [31:0]      t_q;
  logic [31:0]      radius_q;
  logic [CNT_W-1:0] n_q;
  logic [IDX_W-1:0] k_q;
  logic [1:0]       ax_q;
  logic [63:0]      b1_q, b2_q, prod_q, ck_q, p0_q, p1_q;
  logic [63:0]      res_q [NUM_AXES];

  // Input decode.
  logic             in_acc;
  logic             is_eval;
  logic             is_deriv;
  logic [CNT_W-1:0] n_clamp;
  logic             short_path;

  assign in_acc   = in_valid_i && in_ready_o;
  assign is_deriv = in_data_i.func == FUNC_DERIV;
  assign is_eval  = (in_data_i.func == FUNC_POS) || is_deriv;
  assign n_clamp  = (term_count_q == '0) ? CNT_W'(1) :
                    ((32'(term_count_q) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : term_count_q);
  assign short_path = is_deriv && ((n_clamp < CNT_W'(2)) || (in_data_i.radius_days == '0));

  // Coefficient store.
  logic      mem_we;
  cce_coef_t mem_wdata;
  cce_coef_t mem_rdata;
  logic [63:0] coef;

  assign mem_we    = in_acc && (in_data_i.func == FUNC_LOAD) &&
                     (32'(in_data_i.term_index) < MAX_TERMS);
  assign mem_wdata = '{x: in_data_i.coef_x, y: in_data_i.coef_y, z: in_data_i.coef_z};

  cce_coef_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (IDX_W'(in_data_i.term_index)),
    .wr_data_i (mem_wdata),
    .rd_en_i   (state_q == S_RD),
    .rd_addr_i (k_q),
    .rd_data_o (mem_rdata)
  );

  always_comb begin
    case (ax_q)
      2'd0:    coef = mem_rdata.x;
      2'd1:    coef = mem_rdata.y;
      default: coef = mem_rdata.z;
    endcase
  end

  // Shared 32x32 multiplier: the low then high half of |b1| times |t| or 43200.
  logic [63:0] b1_mag;
  logic [31:0] t_mag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        hi_half, scale_ph;

  assign b1_mag   = mag64(b1_q);
  assign t_mag    = t_q[31] ? (~t_q + 32'd1) : t_q;
  assign hi_half  = (state_q == S_MUL1) || (state_q == S_SC1);
  assign scale_ph = (state_q == S_SC0) || (state_q == S_SC1);
  assign mul_a    = hi_half ? b1_mag[63:32] : b1_mag[31:0];
  assign mul_b    = scale_ph ? HALF_DAY_SCALE : t_mag;
  assign mul_p    = mul_a * mul_b;

  // Recombined 96-bit product and its rounded, saturated form.
  logic [95:0] m96;
  logic [95:0] m_rnd;
  logic        last_pos;
  logic [64:0] prod_pk;

  assign last_pos = !deriv_q && (k_q == '0);
  assign m96      = {32'b0, p0_q} + {p1_q, 32'b0};
  assign m_rnd    = last_pos ? ((m96 + 96'(1 << 29)) >> 30) : ((m96 + 96'(1 << 28)) >> 29);
  assign prod_pk  = pack_mag(128'(m_rnd), b1_q[63] ^ t_q[31]);

  // Derivative term weight 2k times the coefficient.
  logic [IDX_W:0] k2;
  logic [70:0]    small_p;
  logic [64:0]    ck_pk;

  assign k2      = {k_q, 1'b0};
  assign small_p = mag64(coef) * k2;
  assign ck_pk   = pack_mag(128'(small_p), coef[63]);

  // Recurrence step: prod - b2 + c.
  logic [64:0] sub_r, add_r;

  assign sub_r = ssub(prod_q, b2_q);
  assign add_r = sadd(sub_r[63:0], ck_q);

  // Final scale divide.
  logic              div_busy, div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [31:0]       div_rem;
  logic              rnd_up;
  logic [DIV_W:0]    q_rnd;
  logic [64:0]       scale_pk;

  cce_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DVS),
    .dividend_i ({m96[79:0], 20'b0}),
    .divisor_i  (radius_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign rnd_up   = {div_rem, 1'b0} >= {1'b0, radius_q};
  assign q_rnd    = {1'b0, div_quot} + (DIV_W + 1)'(rnd_up);
  assign scale_pk = pack_mag(128'(q_rnd), b1_q[63]);

  logic out_free;
  logic last_ax;

  assign out_free = !out_valid_q || out_ready_i;
  assign last_ax  = ax_q == 2'd2;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_eval) begin
          state_d = short_path ? S_DONE : S_RD;
        end
      end
      S_RD:   state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_RND;
      S_RND:  state_d = S_ACC;
      S_ACC: begin
        if (last_pos) begin
          state_d = last_ax ? S_DONE : S_RD;
        end else if (deriv_q && (k_q == IDX_W'(1))) begin
          state_d = S_SC0;
        end else begin
          state_d = S_RD;
        end
      end
      S_SC0: state_d = S_SC1;
      S_SC1: state_d = S_DVS;
      S_DVS: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = last_ax ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      term_count_q <= CNT_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        term_count_q <= cfg_data_i;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_eval) begin
          deriv_q  <= is_deriv;
          rad0_q   <= is_deriv && (n_clamp >= CNT_W'(2)) && (in_data_i.radius_days == '0);
          t_q      <= in_data_i.t_norm;
          radius_q <= in_data_i.radius_days;
          n_q      <= n_clamp;
          k_q      <= IDX_W'(n_clamp - CNT_W'(1));
          ax_q     <= 2'd0;
          b1_q     <= '0;
          b2_q     <= '0;
          sat_q    <= 1'b0;
          if (short_path) begin
            res_q[0] <= '0;
            res_q[1] <= '0;
            res_q[2] <= '0;
          end
        end
      end
      S_MUL0: begin
        p0_q <= mul_p;
        if (deriv_q) begin
          ck_q  <= ck_pk[63:0];
          sat_q <= sat_q | ck_pk[64];
        end else begin
          ck_q <= coef;
        end
      end
      S_MUL1: p1_q <= mul_p;
      S_RND: begin
        prod_q <= prod_pk[63:0];
        sat_q  <= sat_q | prod_pk[64];
      end
      S_ACC: begin
        sat_q <= sat_q | sub_r[64] | add_r[64];
        if (last_pos) begin
          res_q[ax_q] <= add_r[63:0];
          ax_q        <= ax_q + 2'd1;
          k_q         <= IDX_W'(n_q - CNT_W'(1));
          b1_q        <= '0;
          b2_q        <= '0;
        end else begin
          b2_q <= b1_q;
          b1_q <= add_r[63:0];
          if (!(deriv_q && (k_q == IDX_W'(1)))) begin
            k_q <= k_q - IDX_W'(1);
          end
        end
      end
      S_SC0: p0_q <= mul_p;
      S_SC1: p1_q <= mul_p;
      S_DIV: begin
        if (div_done) begin
          res_q[ax_q] <= scale_pk[63:0];
          sat_q       <= sat_q | scale_pk[64];
          ax_q        <= ax_q + 2'd1;
          k_q         <= IDX_W'(n_q - CNT_W'(1));
          b1_q        <= '0;
          b2_q        <= '0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_q.out_x  <= res_q[0];
          out_data_q.out_y  <= res_q[1];
          out_data_q.out_z  <= res_q[2];
          out_data_q.status <= rad0_q ? ST_ZERO_RAD : (sat_q ? ST_SAT : ST_OK);
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CCE_ASSERT_NXT(a_eval_blocks_input, in_valid_i && in_ready_o && (in_data_i.func == FUNC_POS || in_data_i.func == FUNC_DERIV), !in_ready_o, "evaluation word did not block the input")
  `CCE_ASSERT_IMP(a_read_in_range, state_q == S_RD, ({1'b0, k_q} < n_q), "term read beyond term count")
  `CCE_ASSERT_IMP(a_zero_radius_out, out_valid_o && out_data_o.status == ST_ZERO_RAD, (out_data_o.out_x == '0) && (out_data_o.out_y == '0) && (out_data_o.out_z == '0), "zero radius result not zero")
  `CCE_ASSERT_IMP(a_div_in_state, div_busy || div_done, state_q == S_DIV, "divider active outside divide state")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cce_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [63:0] MINNEG64 = 64'h8000_0000_0000_0000;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [5:0]  cfg_val;
    cce_in_t     word;
    bit          typed;
    cce_out_t    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cce_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cce_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i = '0;

  // Testbench copy of the block state.
  logic [63:0] coef_x_mem [MAX_TERMS];
  logic [63:0] coef_y_mem [MAX_TERMS];
  logic [63:0] coef_z_mem [MAX_TERMS];
  bit written [MAX_TERMS];
  logic [5:0] terms_reg;
  bit ovf;

  cce_out_t pending_results[$];
  row_t stim_rows[$];
  int errors = 0;
  int n_pos = 0, n_deriv = 0, n_load = 0, n_sat = 0, n_zrad = 0;
  int burst_left = 0;
  longint cycles = 0;

  chebyshev_clenshaw_eval_3d dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Fixed-point helpers for the series predictor; ovf collects saturation.
  function automatic logic [63:0] abs64(input logic [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic [63:0] clamp_mag(input logic [127:0] m, input bit neg);
    logic [63:0] lim;
    logic [63:0] v;
    lim = neg ? MINNEG64 : MAXPOS64;
    v = m[63:0];
    if (m > {64'd0, lim}) begin
      ovf = 1'b1;
      v = lim;
    end
    return neg ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      ovf = 1'b1;
      r = a[63] ? MINNEG64 : MAXPOS64;
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      ovf = 1'b1;
      r = a[63] ? MINNEG64 : MAXPOS64;
    end
    return r;
  endfunction

  // Product by t, rounded to nearest with ties away from zero.
  function automatic logic [63:0] times_t(input logic [63:0] a, input logic [31:0] t,
                                          input int shift);
    logic [31:0] tm;
    logic [127:0] m;
    tm = t[31] ? (~t + 32'd1) : t;
    m = {64'd0, abs64(a)} * {96'd0, tm};
    m = (m + (128'd1 << (shift - 1))) >> shift;
    return clamp_mag(m, a[63] ^ t[31]);
  endfunction

  // Velocity scale: |d| * 43200 * 2^20 / radius, rounded half up in magnitude.
  function automatic logic [63:0] day_scale(input logic [63:0] d, input logic [31:0] rad);
    logic [127:0] m;
    logic [127:0] q;
    logic [127:0] rem;
    m = ({64'd0, abs64(d)} * 128'd43200) << 20;
    q = m / {96'd0, rad};
    rem = m % {96'd0, rad};
    if (rem >= {96'd0, rad} - rem) q = q + 128'd1;
    return clamp_mag(q, d[63]);
  endfunction

  function automatic logic [63:0] coef_at(input int ax, input int k);
    case (ax)
      0: return coef_x_mem[k];
      1: return coef_y_mem[k];
      default: return coef_z_mem[k];
    endcase
  endfunction

  function automatic int clamped_terms();
    if (terms_reg == 0) return 1;
    if (terms_reg > MAX_TERMS) return MAX_TERMS;
    return int'(terms_reg);
  endfunction

  // Clenshaw evaluation of position or derivative for one word.
  function automatic cce_out_t predict_series(input cce_in_t w);
    cce_out_t r;
    logic [63:0] b1, b2, v, ck, cv;
    logic [63:0] axis_val [3];
    int n;
    n = clamped_terms();
    ovf = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      b1 = '0;
      b2 = '0;
      if (w.func == FUNC_POS) begin
        for (int k = n - 1; k > 0; k--) begin
          v = add_sat(sub_sat(times_t(b1, w.t_norm, 29), b2), coef_at(ax, k));
          b2 = b1;
          b1 = v;
        end
        axis_val[ax] = add_sat(sub_sat(times_t(b1, w.t_norm, 30), b2), coef_at(ax, 0));
      end else if (n < 2) begin
        axis_val[ax] = '0;
      end else begin
        for (int k = n - 1; k > 0; k--) begin
          cv = coef_at(ax, k);
          ck = clamp_mag({64'd0, abs64(cv)} * (128'd2 * k), cv[63]);
          v = add_sat(sub_sat(times_t(b1, w.t_norm, 29), b2), ck);
          b2 = b1;
          b1 = v;
        end
        axis_val[ax] = (w.radius_days == 0) ? 64'd0 : day_scale(b1, w.radius_days);
      end
    end
    r.out_x = axis_val[0];
    r.out_y = axis_val[1];
    r.out_z = axis_val[2];
    if (w.func == FUNC_DERIV && n >= 2 && w.radius_days == 0) r.status = ST_ZERO_RAD;
    else if (ovf) r.status = ST_SAT;
    else r.status = ST_OK;
    return r;
  endfunction

  // Apply an accepted word to the model state and queue its result, if any.
  task automatic note_accepted(input cce_in_t w, input bit typed, input cce_out_t want);
    cce_out_t r;
    if (w.func == FUNC_LOAD) begin
      coef_x_mem[w.term_index] = w.coef_x;
      coef_y_mem[w.term_index] = w.coef_y;
      coef_z_mem[w.term_index] = w.coef_z;
      written[w.term_index] = 1'b1;
      n_load++;
    end else if (w.func != FUNC_NOP) begin
      r = typed ? want : predict_series(w);
      if (w.func == FUNC_POS) n_pos++;
      else n_deriv++;
      if (r.status == ST_SAT) n_sat++;
      if (r.status == ST_ZERO_RAD) n_zrad++;
      pending_results.push_back(r);
    end
  endtask

  // Drive one word, with bursts and random gaps on the sender side.
  task automatic send_word(input cce_in_t w, input bit typed, input cce_out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    note_accepted(w, typed, want);
  endtask

  // Wait for the block to drain, then write the term count.
  task automatic write_terms(input logic [5:0] val);
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    terms_reg = val;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [5:0] cfg_val,
                         input logic [1:0] func, input logic [4:0] idx,
                         input logic [63:0] cx, input logic [63:0] cy,
                         input logic [63:0] cz, input logic [31:0] t,
                         input logic [31:0] rad, input bit typed,
                         input logic [63:0] ex, input logic [63:0] ey,
                         input logic [63:0] ez, input logic [1:0] st);
    row_t r;
    r.kind = kind;
    r.cfg_val = cfg_val;
    r.word = '{func, idx, cx, cy, cz, t, rad};
    r.typed = typed;
    r.want = '{ex, ey, ez, st};
    stim_rows.push_back(r);
  endtask

  function automatic logic [63:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return $urandom_range(0, 1) ? MAXPOS64 : MINNEG64;
      2: return {{24{1'b0}}, $urandom, 8'(($urandom))};
      default: return {{20{1'b0}}, 12'($urandom), $urandom} - 64'h0000_0800_0000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
      default: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'($urandom_range(1, 255));
      default: return 32'($urandom_range(32'h0010_0000, 32'h0400_0000));
    endcase
  endfunction

  // A random word; evaluations only once every term in use has been loaded.
  function automatic cce_in_t rand_word();
    cce_in_t w;
    int sel, n;
    n = clamped_terms();
    sel = $urandom_range(0, 99);
    w.term_index = 5'($urandom);
    w.coef_x = rand_coef();
    w.coef_y = rand_coef();
    w.coef_z = rand_coef();
    w.t_norm = rand_time();
    w.radius_days = rand_radius();
    if (sel < 30) w.func = FUNC_LOAD;
    else if (sel < 60) w.func = FUNC_POS;
    else if (sel < 96) w.func = FUNC_DERIV;
    else w.func = FUNC_NOP;
    if (w.func == FUNC_POS || w.func == FUNC_DERIV) begin
      for (int k = n - 1; k >= 0; k--) begin
        if (!written[k]) begin
          w.func = FUNC_LOAD;
          w.term_index = 5'(k);
        end
      end
    end
    return w;
  endfunction

  // Receiver: ready pattern changes mode every window.
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 200);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 0);
        2: out_ready_i <= ($urandom_range(0, 9) == 0);
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each output word with the oldest expectation.
  always @(posedge clk_i) begin
    cce_out_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, out_data_o);
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data_o.out_x !== exp_w.out_x) begin
          errors++;
          $display("%0t: out_x expected %h actual %h", $time, exp_w.out_x, out_data_o.out_x);
        end
        if (out_data_o.out_y !== exp_w.out_y) begin
          errors++;
          $display("%0t: out_y expected %h actual %h", $time, exp_w.out_y, out_data_o.out_y);
        end
        if (out_data_o.out_z !== exp_w.out_z) begin
          errors++;
          $display("%0t: out_z expected %h actual %h", $time, exp_w.out_z, out_data_o.out_z);
        end
        if (out_data_o.status !== exp_w.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_w.status,
                   out_data_o.status);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
      $display("[chebyshev_clenshaw_eval_3d] ERROR");
      $finish;
    end
  end

  initial begin
    logic [5:0] phase_terms [12];
    cce_out_t none;
    int words;
    none = '0;
    terms_reg = 6'd1;
    foreach (written[k]) written[k] = 1'b0;
    phase_terms = '{6'd2, 6'd3, 6'd32, 6'd5, 6'd0, 6'd8, 6'd63, 6'd4,
                    6'd17, 6'd2, 6'd1, 6'd6};

    // Directed table; typed results only where the outcome is plain.
    add_row(ROW_WORD, 0, FUNC_LOAD, 0, MAXPOS64, MINNEG64, 64'd0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_POS, 0, 0, 0, 0, 32'd0, 0, 1,
            MAXPOS64, MINNEG64, 64'd0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'h4000_0000, 32'h0010_0000, 1,
            0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_NOP, 5'h1F, '1, '1, '1, '1, '1, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_LOAD, 1, 64'h80_0000, -64'sd8388608, 64'd1,
            0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CFG, 6'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_POS, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_POS, 0, 0, 0, 0, 32'hC000_0000, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_POS, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'h1234_5678, 32'd0, 1,
            0, 0, 0, ST_ZERO_RAD);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'h4000_0000, 32'd1, 0,
            0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'h4000_0000, 32'hFFFF_FFFF, 0,
            0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_LOAD, 1, MAXPOS64, MINNEG64, MAXPOS64, 0, 0, 0,
            0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_POS, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h0010_0000, 0,
            0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_LOAD, 2, 64'h0000_0123_4567_89AB, 64'd5, -64'sd7,
            0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_LOAD, 3, -64'sd1, 64'h0000_7FFF_0000_0000, 64'd3,
            0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_CFG, 6'd4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_POS, 0, 0, 0, 0, 32'h2000_0000, 0, 0, 0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'hE000_0000, 32'h0100_0000, 0,
            0, 0, 0, ST_OK);
    add_row(ROW_WORD, 0, FUNC_DERIV, 0, 0, 0, 0, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0, ST_OK);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) write_terms(stim_rows[i].cfg_val);
      else send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
    end

    // Random phases, each under its own term count; long counts get fewer words.
    foreach (phase_terms[p]) begin
      write_terms(phase_terms[p]);
      words = (clamped_terms() > 16) ? 40 : 170;
      for (int i = 0; i < words; i++) send_word(rand_word(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d loads, %0d position and %0d derivative words", n_load, n_pos,
             n_deriv);
    $display("over 14 term counts; %0d saturated, %0d zero radius", n_sat, n_zrad);
    if (errors == 0) begin
      $display("[chebyshev_clenshaw_eval_3d] OK");
    end else begin
      $display("[chebyshev_clenshaw_eval_3d] ERROR");
    end
    $finish;
  end

endmodule
